[rtl/akhp_pkg.sv]
// Shared types and constants for the AX.25 KISS header parser.
`timescale 1ns / 1ps

package akhp_pkg;

  // Parse phase of the current frame
  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_HDR1    = 4'd1,
    PH_DST     = 4'd2,
    PH_SRC     = 4'd3,
    PH_DIGI    = 4'd4,
    PH_CTRL    = 4'd5,
    PH_PID     = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_DISCARD = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DST     = 3'd0,
    KIND_SRC     = 3'd1,
    KIND_DIGI    = 3'd2,
    KIND_CTRLPID = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_STATUS  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_MANY_DIGI = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  localparam logic [7:0] KISS_FEND      = 8'hC0;
  localparam logic [7:0] KISS_CMD_DATA  = 8'h00;
  localparam logic [6:0] CALL_SPACE     = 7'h20;
  localparam logic [2:0] CALL_CHARS     = 3'd6;
  localparam logic [7:0] MIN_BYTES_RST  = 8'd12;
  localparam logic [7:0] COUNT_SAT      = 8'hFF;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    kind_e        kind;
    logic [47:0]  callsign;
    logic [3:0]   ssid;
    logic [7:0]   control;
    logic [7:0]   protocol_id;
    logic [7:0]   payload_byte;
    status_e      status;
    logic         last;
  } record_t;

endpackage

[rtl/ax25_kiss_header_parser_unit.sv]
// Top level: AX.25 address header parser for KISS frames, one byte per request.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+----------------------------------------
// s_axis   | in  | s_axis_tvalid/tready    | tdata[7:0] rx_byte, tlast frame_end
// m_axis   | out | m_axis_tvalid/tready    | tdata callsign..status, tuser record_kind,
//          |     |                         | tlast last_in_run
// cfg      | in  | cfg_valid/cfg_ready     | cfg_data[7:0] min_frame_bytes
//
// Each byte is parsed in the cycle it is taken and its results (none, one or two)
// are written straight into a four-entry result queue that drives the master side.
// A byte is taken whenever the queue has room for two results, so with a free-running
// sink one byte a cycle is sustained; a byte that yields two results (a record plus
// the frame status) puts both into the queue, and they leave it one at a time.
// Reset clears all parse state and empties the queue; min_frame_bytes returns to 12.
// A stalled sink fills the queue past two entries; s_axis_tready is then held low.

module ax25_kiss_header_parser_unit #(
  parameter int unsigned MAX_DIGIS   = 8,
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // frame_end
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [47:0] callsign, [51:48] ssid, [59:52] control, [67:60] protocol_id,
  // [75:68] payload_byte, [78:76] status, [79] zero
  output logic [79:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,   // [2:0] record_kind
  output logic        m_axis_tlast_o,   // last_in_run
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i        // min_frame_bytes
);

  localparam int unsigned PCW = $clog2(MAX_PAYLOAD + 1);

  // Parse state
  akhp_pkg::phase_e  phase_q, phase_d, phase_nx;
  logic [2:0]        bif_q, bif_d;
  logic [47:0]       call_q, call_d;
  logic [7:0]        fcnt_q, fcnt_d;
  logic [3:0]        digi_q, digi_d;
  logic [PCW-1:0]    pay_q, pay_d;
  logic [7:0]        ctrl_q, ctrl_d;
  akhp_pkg::status_e err_q, err_d, err_nx;
  logic [7:0]        min_bytes_q;

  // Result queue
  akhp_pkg::record_t                 queue_q [akhp_pkg::QDEPTH];
  logic [akhp_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [akhp_pkg::QCNT_W-1:0]       cnt_q;

  logic              s_acc, m_acc;
  logic [7:0]        rx_b;
  logic              fend;
  logic              in_addr, addr_done, ext;
  logic [3:0]        digi_after;
  logic [6:0]        call_char;
  logic              own_vld;
  akhp_pkg::record_t own_rec, stat_rec;
  akhp_pkg::status_e stat_code;
  logic [7:0]        fcnt_inc;
  logic [1:0]        n_push;

  assign rx_b  = s_axis_tdata_i;
  assign fend  = s_axis_tlast_i;
  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o & m_axis_tready_i;

  // Room for a record and a status before the byte is taken
  assign s_axis_tready_o = (cnt_q <= akhp_pkg::QCNT_W'(akhp_pkg::QDEPTH - 2));
  assign cfg_ready_o     = 1'b1;

  assign in_addr    = (phase_q == akhp_pkg::PH_DST) || (phase_q == akhp_pkg::PH_SRC) ||
                      (phase_q == akhp_pkg::PH_DIGI);
  assign addr_done  = in_addr && (bif_q >= akhp_pkg::CALL_CHARS);
  assign ext        = rx_b[0];
  assign digi_after = digi_q + 4'((phase_q == akhp_pkg::PH_DIGI) ? 1 : 0);
  assign fcnt_inc   = fcnt_q + 8'((fcnt_q != akhp_pkg::COUNT_SAT) ? 1 : 0);
  assign call_char  = (rx_b[7:1] == akhp_pkg::CALL_SPACE) ? 7'd0 : rx_b[7:1];

  // Next phase of the parse
  always_comb begin
    phase_nx = phase_q;
    case (phase_q)
      akhp_pkg::PH_HDR0: begin
        phase_nx = (rx_b == akhp_pkg::KISS_FEND) ? akhp_pkg::PH_HDR1
                                                 : akhp_pkg::PH_DISCARD;
      end
      akhp_pkg::PH_HDR1: begin
        phase_nx = (rx_b == akhp_pkg::KISS_CMD_DATA) ? akhp_pkg::PH_DST
                                                     : akhp_pkg::PH_DISCARD;
      end
      akhp_pkg::PH_DST, akhp_pkg::PH_SRC, akhp_pkg::PH_DIGI: begin
        if (addr_done) begin
          // destination extension bit is ignored: the source always follows
          if (phase_q == akhp_pkg::PH_DST) begin
            phase_nx = akhp_pkg::PH_SRC;
          end else if (ext) begin
            phase_nx = akhp_pkg::PH_CTRL;
          end else if (digi_after >= 4'(MAX_DIGIS)) begin
            phase_nx = akhp_pkg::PH_DISCARD;
          end else begin
            phase_nx = akhp_pkg::PH_DIGI;
          end
        end
      end
      akhp_pkg::PH_CTRL:    phase_nx = akhp_pkg::PH_PID;
      akhp_pkg::PH_PID:     phase_nx = akhp_pkg::PH_PAYLOAD;
      akhp_pkg::PH_PAYLOAD: begin
        if (pay_q >= PCW'(MAX_PAYLOAD)) begin
          phase_nx = akhp_pkg::PH_DISCARD;
        end
      end
      akhp_pkg::PH_DISCARD: phase_nx = akhp_pkg::PH_DISCARD;
      default:              phase_nx = akhp_pkg::PH_DISCARD;
    endcase
    // frame end restarts the parse on the KISS header
    phase_d = fend ? akhp_pkg::PH_HDR0 : phase_nx;
  end

  // Datapath: field gathering, counters, error and the records of this byte
  always_comb begin
    bif_d   = bif_q;
    call_d  = call_q;
    digi_d  = digi_q;
    pay_d   = pay_q;
    ctrl_d  = ctrl_q;
    err_nx  = err_q;
    own_vld = 1'b0;
    own_rec = '0;

    case (phase_q)
      akhp_pkg::PH_HDR0: begin
        if (rx_b != akhp_pkg::KISS_FEND) begin
          err_nx = akhp_pkg::ST_BAD_HDR;
        end
      end
      akhp_pkg::PH_HDR1: begin
        if (rx_b != akhp_pkg::KISS_CMD_DATA) begin
          err_nx = akhp_pkg::ST_BAD_HDR;
        end else begin
          bif_d  = '0;
          call_d = '0;
        end
      end
      akhp_pkg::PH_DST, akhp_pkg::PH_SRC, akhp_pkg::PH_DIGI: begin
        if (!addr_done) begin
          // shift in one callsign character, spaces become null
          call_d = {call_q[39:0], 1'b0, call_char};
          bif_d  = bif_q + 3'd1;
        end else begin
          own_vld      = 1'b1;
          own_rec.kind = (phase_q == akhp_pkg::PH_DST) ? akhp_pkg::KIND_DST :
                         (phase_q == akhp_pkg::PH_SRC) ? akhp_pkg::KIND_SRC :
                                                         akhp_pkg::KIND_DIGI;
          own_rec.callsign = call_q;
          own_rec.ssid     = rx_b[4:1];
          bif_d  = '0;
          call_d = '0;
          digi_d = digi_after;
          if ((phase_q != akhp_pkg::PH_DST) && !ext && (digi_after >= 4'(MAX_DIGIS))) begin
            err_nx = akhp_pkg::ST_MANY_DIGI;
          end
        end
      end
      akhp_pkg::PH_CTRL: ctrl_d = rx_b;
      akhp_pkg::PH_PID: begin
        own_vld             = 1'b1;
        own_rec.kind        = akhp_pkg::KIND_CTRLPID;
        own_rec.control     = ctrl_q;
        own_rec.protocol_id = rx_b;
      end
      akhp_pkg::PH_PAYLOAD: begin
        if (pay_q < PCW'(MAX_PAYLOAD)) begin
          pay_d                = pay_q + PCW'(1);
          own_vld              = 1'b1;
          own_rec.kind         = akhp_pkg::KIND_PAYLOAD;
          own_rec.payload_byte = rx_b;
        end else begin
          err_nx = akhp_pkg::ST_OVERFLOW;
        end
      end
      default: begin
      end
    endcase
    own_rec.last = !fend;

    // Status priority: too short, then a recorded error, then truncated
    if (fcnt_inc < min_bytes_q) begin
      stat_code = akhp_pkg::ST_SHORT;
    end else if (err_nx != akhp_pkg::ST_OK) begin
      stat_code = err_nx;
    end else if (phase_nx != akhp_pkg::PH_PAYLOAD) begin
      stat_code = akhp_pkg::ST_TRUNC;
    end else begin
      stat_code = akhp_pkg::ST_OK;
    end
    stat_rec        = '0;
    stat_rec.kind   = akhp_pkg::KIND_STATUS;
    stat_rec.status = stat_code;
    stat_rec.last   = 1'b1;

    // Drop all per-frame state at frame end
    err_d  = err_nx;
    fcnt_d = fcnt_inc;
    if (fend) begin
      bif_d  = '0;
      call_d = '0;
      digi_d = '0;
      pay_d  = '0;
      ctrl_d = '0;
      err_d  = akhp_pkg::ST_OK;
      fcnt_d = '0;
    end

    n_push = {1'b0, own_vld} + {1'b0, fend};
  end

  // Parse state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= akhp_pkg::PH_HDR0;
      bif_q       <= '0;
      call_q      <= '0;
      fcnt_q      <= '0;
      digi_q      <= '0;
      pay_q       <= '0;
      ctrl_q      <= '0;
      err_q       <= akhp_pkg::ST_OK;
      min_bytes_q <= akhp_pkg::MIN_BYTES_RST;
    end else begin
      if (s_acc) begin
        phase_q <= phase_d;
        bif_q   <= bif_d;
        call_q  <= call_d;
        fcnt_q  <= fcnt_d;
        digi_q  <= digi_d;
        pay_q   <= pay_d;
        ctrl_q  <= ctrl_d;
        err_q   <= err_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        min_bytes_q <= cfg_data_i;
      end
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s_acc) begin
        wr_ptr_q <= wr_ptr_q + akhp_pkg::QPTR_W'(n_push);
      end
      if (m_acc) begin
        rd_ptr_q <= rd_ptr_q + akhp_pkg::QPTR_W'(1);
      end
      cnt_q <= cnt_q + akhp_pkg::QCNT_W'(s_acc ? n_push : 2'd0)
                     - akhp_pkg::QCNT_W'(m_acc ? 1 : 0);
    end
  end

  // Queue payload: the byte's own record first, the status behind it
  always_ff @(posedge clk_i) begin
    if (s_acc && own_vld) begin
      queue_q[wr_ptr_q] <= own_rec;
    end
    if (s_acc && fend) begin
      queue_q[wr_ptr_q + akhp_pkg::QPTR_W'(own_vld)] <= stat_rec;
    end
  end

  akhp_pkg::record_t head;
  assign head            = queue_q[rd_ptr_q];
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {1'b0, head.status, head.payload_byte, head.protocol_id,
                            head.control, head.ssid, head.callsign};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;

  // Checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= akhp_pkg::QCNT_W'(akhp_pkg::QDEPTH))
    else $error("result queue over-filled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == akhp_pkg::KIND_STATUS)) |-> m_axis_tlast_o)
    else $error("status record not last of its run");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> (phase_q == akhp_pkg::PH_HDR0) && (fcnt_q == '0))
    else $error("parse state not cleared after frame end");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !m_acc) |=> (cnt_q <= akhp_pkg::QCNT_W'(akhp_pkg::QDEPTH)))
    else $error("byte taken without queue room");

endmodule

[test/ax25_kiss_header_parser_unit_tb.sv]
// Self-checking testbench for the AX.25 KISS header parser unit.
`timescale 1ns / 1ps

module ax25_kiss_header_parser_unit_tb;

  localparam int unsigned DIGI_LIMIT    = 8;
  localparam int unsigned PAYLOAD_LIMIT = 256;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;   // result queue is registered; allow a margin
  localparam int unsigned LONG_HOLD     = 80;

  // Directed frame: callsigns with spaces, a high byte, a space with bit zero set,
  // destination extension bit set (ignored), full SSID, payload ending in a FEND.
  localparam logic [7:0] DIRECTED_FRAME [20] = '{
    8'hC0, 8'h00,
    8'h82, 8'hB4, 8'h40, 8'h60, 8'hFF, 8'h00, 8'hE1,
    8'h9C, 8'h40, 8'h40, 8'h40, 8'h40, 8'h41, 8'h1F,
    8'h03, 8'hF0, 8'hFF, 8'hC0
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
  } kiss_byte_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;   // [7:0] rx_byte
  logic        s_axis_tlast_i  = 1'b0;    // frame_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [47:0] callsign, [51:48] ssid, [59:52] control, [67:60] protocol_id,
  // [75:68] payload_byte, [78:76] status, [79] zero
  logic [79:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;            // [2:0] record_kind
  logic        m_axis_tlast_o;            // last_in_run
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i      = 8'h00;   // min_frame_bytes

  // Bytes waiting to be offered, and records the parser owes us
  kiss_byte_t          pending_bytes[$];
  akhp_pkg::record_t   expected_records[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_idle_pct  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count   = 0;

  // Shadow of the parser state
  logic [7:0]        min_bytes;
  akhp_pkg::phase_e  parse_phase;
  int unsigned       field_pos;
  logic [47:0]       call_acc;
  logic [15:0]       frame_len;
  int unsigned       digi_seen;
  int unsigned       pay_seen;
  logic [7:0]        held_control;
  akhp_pkg::status_e frame_err;

  ax25_kiss_header_parser_unit #(
    .MAX_DIGIS  (DIGI_LIMIT),
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Return all per-frame shadow state to its reset value; the threshold survives.
  function automatic void clear_frame();
    parse_phase  = akhp_pkg::PH_HDR0;
    field_pos    = 0;
    call_acc     = '0;
    frame_len    = '0;
    digi_seen    = 0;
    pay_seen     = 0;
    held_control = '0;
    frame_err    = akhp_pkg::ST_OK;
  endfunction

  // Advance the shadow parser by one byte and queue the records it yields.
  function automatic void parse_kiss_byte(logic [7:0] b, logic fend);
    akhp_pkg::record_t recs[2];
    int                n;
    logic [6:0]        ch;
    akhp_pkg::status_e st;
    n = 0;
    if (frame_len != 16'hFFFF) frame_len++;

    case (parse_phase)
      akhp_pkg::PH_HDR0: begin
        if (b == akhp_pkg::KISS_FEND) begin
          parse_phase = akhp_pkg::PH_HDR1;
        end else begin
          frame_err   = akhp_pkg::ST_BAD_HDR;
          parse_phase = akhp_pkg::PH_DISCARD;
        end
      end
      akhp_pkg::PH_HDR1: begin
        if (b == akhp_pkg::KISS_CMD_DATA) begin
          parse_phase = akhp_pkg::PH_DST;
          field_pos   = 0;
          call_acc    = '0;
        end else begin
          frame_err   = akhp_pkg::ST_BAD_HDR;
          parse_phase = akhp_pkg::PH_DISCARD;
        end
      end
      akhp_pkg::PH_DST, akhp_pkg::PH_SRC, akhp_pkg::PH_DIGI: begin
        if (field_pos < akhp_pkg::CALL_CHARS) begin
          // shift the character down and blank out spaces
          ch = b[7:1];
          if (ch == akhp_pkg::CALL_SPACE) ch = '0;
          call_acc = {call_acc[39:0], 1'b0, ch};
          field_pos++;
        end else begin
          recs[n] = '0;
          if (parse_phase == akhp_pkg::PH_DST) recs[n].kind = akhp_pkg::KIND_DST;
          else if (parse_phase == akhp_pkg::PH_SRC) recs[n].kind = akhp_pkg::KIND_SRC;
          else recs[n].kind = akhp_pkg::KIND_DIGI;
          recs[n].callsign = call_acc;
          recs[n].ssid     = b[4:1];
          n++;
          field_pos = 0;
          call_acc  = '0;
          if (parse_phase == akhp_pkg::PH_DST) begin
            // destination extension bit is ignored: the source always follows
            parse_phase = akhp_pkg::PH_SRC;
          end else begin
            if (parse_phase == akhp_pkg::PH_DIGI) digi_seen++;
            if (b[0]) begin
              parse_phase = akhp_pkg::PH_CTRL;
            end else if (digi_seen >= DIGI_LIMIT) begin
              frame_err   = akhp_pkg::ST_MANY_DIGI;
              parse_phase = akhp_pkg::PH_DISCARD;
            end else begin
              parse_phase = akhp_pkg::PH_DIGI;
            end
          end
        end
      end
      akhp_pkg::PH_CTRL: begin
        held_control = b;
        parse_phase  = akhp_pkg::PH_PID;
      end
      akhp_pkg::PH_PID: begin
        recs[n]             = '0;
        recs[n].kind        = akhp_pkg::KIND_CTRLPID;
        recs[n].control     = held_control;
        recs[n].protocol_id = b;
        n++;
        parse_phase = akhp_pkg::PH_PAYLOAD;
      end
      akhp_pkg::PH_PAYLOAD: begin
        if (pay_seen < PAYLOAD_LIMIT) begin
          pay_seen++;
          recs[n]              = '0;
          recs[n].kind         = akhp_pkg::KIND_PAYLOAD;
          recs[n].payload_byte = b;
          n++;
        end else begin
          // drop this byte and the rest of the frame
          frame_err   = akhp_pkg::ST_OVERFLOW;
          parse_phase = akhp_pkg::PH_DISCARD;
        end
      end
      default: ;
    endcase

    if (fend) begin
      if (frame_len < min_bytes) st = akhp_pkg::ST_SHORT;
      else if (frame_err != akhp_pkg::ST_OK) st = frame_err;
      else if (parse_phase != akhp_pkg::PH_PAYLOAD) st = akhp_pkg::ST_TRUNC;
      else st = akhp_pkg::ST_OK;
      recs[n]        = '0;
      recs[n].kind   = akhp_pkg::KIND_STATUS;
      recs[n].status = st;
      n++;
      clear_frame();
    end

    if (n > 0) recs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_records = {expected_records, recs[i]};
  endfunction

  function automatic void push_byte(logic [7:0] data, logic last);
    kiss_byte_t kb;
    kb.data = data;
    kb.last = last;
    pending_bytes = {pending_bytes, kb};
  endfunction

  // Build one frame: mostly well formed with random content, some with a bad
  // header, a cut-off tail, too many digipeaters, or plain noise.
  function automatic int unsigned add_random_frame(bit long_payload);
    logic [7:0]  frame[$];
    int unsigned style, digis, n_addr, pay_len, cut;
    logic        ext;
    style = long_payload ? 50 : $urandom_range(99);

    if (style < 8) begin
      repeat ($urandom_range(1, 24)) frame = {frame, 8'($urandom_range(255))};
    end else begin
      if (style < 14) begin
        if ($urandom_range(1) == 0) begin
          frame = {frame, 8'($urandom_range(255))};
          if (frame[0] == akhp_pkg::KISS_FEND) frame[0] = 8'h3F;
          frame = {frame, 8'($urandom_range(255))};
        end else begin
          frame = {frame, akhp_pkg::KISS_FEND};
          frame = {frame, 8'($urandom_range(1, 255))};
        end
      end else begin
        frame = {frame, akhp_pkg::KISS_FEND};
        frame = {frame, akhp_pkg::KISS_CMD_DATA};
      end

      if (long_payload) digis = 0;
      else if ($urandom_range(9) == 0) digis = DIGI_LIMIT;
      else digis = $urandom_range(3);
      n_addr = digis + 2;

      for (int a = 0; a < n_addr; a++) begin
        for (int k = 0; k < akhp_pkg::CALL_CHARS; k++) begin
          case ($urandom_range(3))
            0:       frame = {frame, 8'h40};
            3:       frame = {frame, 8'($urandom_range(255))};
            default: frame = {frame, 8'((8'h41 + $urandom_range(25)) << 1)};
          endcase
        end
        if (a == 0) ext = 1'($urandom_range(1));
        else if (a == n_addr - 1)
          ext = (digis == DIGI_LIMIT) ? 1'($urandom_range(1)) : ($urandom_range(9) != 0);
        else ext = ($urandom_range(19) == 0);
        frame = {frame, {3'($urandom_range(7)), 4'($urandom_range(15)), ext}};
      end

      frame = {frame, 8'($urandom_range(255))};   // control
      frame = {frame, 8'($urandom_range(255))};   // PID
      pay_len = long_payload ? PAYLOAD_LIMIT + $urandom_range(1, 3) : $urandom_range(12);
      repeat (pay_len) frame = {frame, 8'($urandom_range(255))};

      if (!long_payload && $urandom_range(9) == 0) begin
        cut = $urandom_range(1, frame.size());
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end

    foreach (frame[i]) push_byte(frame[i], i == frame.size() - 1);
    return frame.size();
  endfunction

  task automatic check_field(input string what, input logic [47:0] want_v,
                             input logic [47:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Write the frame length threshold; only called with the parser idle.
  task automatic write_min_bytes(input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_bytes = value;
  endtask

  // Hold until every byte is taken and every record has come back, then settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid_i || expected_records.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Byte driver: hold a request until taken, otherwise offer the next byte or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'h00;
      s_axis_tlast_i  <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) void'(pending_bytes.pop_front());
      if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_bytes[0].data;
        s_axis_tlast_i  <= pending_bytes[0].last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Record sink: random back-pressure, plus a long hold-off on request so the
  // result queue fills and the parser has to stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served      = hold_requests;
      hold_left        = LONG_HOLD;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: predict on every taken byte first, then check any record handed out
  // at the same edge against the oldest expectation.
  always @(posedge clk_i) begin
    akhp_pkg::record_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) parse_kiss_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual kind %0d data 0x%0h last %0b",
                   $time, m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
          mismatch_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_kind",  want.kind,         m_axis_tuser_o);
          check_field("callsign",     want.callsign,     m_axis_tdata_o[47:0]);
          check_field("ssid",         want.ssid,         m_axis_tdata_o[51:48]);
          check_field("control",      want.control,      m_axis_tdata_o[59:52]);
          check_field("protocol_id",  want.protocol_id,  m_axis_tdata_o[67:60]);
          check_field("payload_byte", want.payload_byte, m_axis_tdata_o[75:68]);
          check_field("status",       want.status,       m_axis_tdata_o[78:76]);
          check_field("pad",          48'h0,             m_axis_tdata_o[79]);
          check_field("last_in_run",  want.last,         m_axis_tlast_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ax25_kiss_header_parser_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned queued;
    min_bytes = akhp_pkg::MIN_BYTES_RST;
    clear_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a full frame at the reset threshold, then two short broken frames
    foreach (DIRECTED_FRAME[i]) push_byte(DIRECTED_FRAME[i], i == 19);
    push_byte(akhp_pkg::KISS_FEND, 1'b0);
    push_byte(8'h05, 1'b1);
    push_byte(8'h00, 1'b1);
    wait_drained();

    // No threshold: a one-byte frame reports its bad header
    write_min_bytes(8'd0);
    push_byte(8'h01, 1'b1);
    wait_drained();

    // Sender mostly busy, sink stalls often
    src_idle_pct = 9;
    snk_idle_pct = 59;
    write_min_bytes(8'($urandom_range(1, 40)));
    queued = 0;
    while (queued < 150) queued += add_random_frame(1'b0);
    wait_drained();

    // Roles swapped, threshold at its top so every frame is too short
    src_idle_pct = 59;
    snk_idle_pct = 9;
    write_min_bytes(8'd255);
    queued = 0;
    while (queued < 150) queued += add_random_frame(1'b0);
    wait_drained();

    // Full rate: payload overflow frame, and a long sink hold-off while bytes queue up
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_min_bytes(8'($urandom_range(0, 20)));
    queued = add_random_frame(1'b1);
    while (queued < 320) queued += add_random_frame(1'b0);
    hold_requests++;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("[ax25_kiss_header_parser_unit] OK");
    end else begin
      $display("[ax25_kiss_header_parser_unit] ERROR");
    end
    $finish;
  end

endmodule
